// File: design/pcpa_pkg.sv
`timescale 1ns / 1ps
package pcpa_pkg;

  localparam int DEF_NUM_CPUS   = 8;
  localparam int DEF_NUM_PAGES  = 32768;
  localparam int DEF_PAGE_SHIFT = 12;

  localparam int ADDR_W      = 32;
  localparam int CPU_IN_W    = 3;
  localparam int PADDR_W     = 3;
  localparam int ST_W        = 2;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [ADDR_W-1:0] DEF_LOWER_BOUND = 32'h8000_0000;
  localparam logic [ADDR_W-1:0] DEF_UPPER_BOUND = 32'h8800_0000;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [ST_W-1:0] {
    ST_DONE = 2'd0,
    ST_OOM  = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  // index width for n entries, never below one bit
  function automatic int idx_width(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  // fold a cpu number into 0..n-1 by repeated subtraction
  function automatic logic [CPU_IN_W-1:0] cpu_wrap(input logic [CPU_IN_W-1:0] v,
                                                   input int n);
    int r;
    r = int'(v);
    for (int i = 0; i < (1 << CPU_IN_W); i++) begin
      if (r >= n) r = r - n;
    end
    return CPU_IN_W'(r);
  endfunction

endpackage

// File: design/pcpa_queue.sv
`timescale 1ns / 1ps
module pcpa_queue #(
  parameter int W     = 8,
  parameter int DEPTH = pcpa_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  localparam int AW = pcpa_pkg::idx_width(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= din;
  end

endmodule

// File: design/pcpa_front.sv
`timescale 1ns / 1ps
module pcpa_front #(
  parameter int NUM_CPUS   = pcpa_pkg::DEF_NUM_CPUS,
  parameter int NUM_PAGES  = pcpa_pkg::DEF_NUM_PAGES,
  parameter int PAGE_SHIFT = pcpa_pkg::DEF_PAGE_SHIFT,
  localparam int CPU_W  = pcpa_pkg::idx_width(NUM_CPUS),
  localparam int PAGE_W = pcpa_pkg::idx_width(NUM_PAGES),
  localparam int PG_W   = pcpa_pkg::ADDR_W + 1 - PAGE_SHIFT,
  localparam int CMD_W  = 2 + CPU_W + PAGE_W
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic                          kind,
  input  logic [pcpa_pkg::CPU_IN_W-1:0] cpu,
  input  logic [pcpa_pkg::ADDR_W-1:0]   page_addr,
  input  logic [pcpa_pkg::ADDR_W-1:0]   lower_bound,
  input  logic [pcpa_pkg::ADDR_W-1:0]   upper_bound,
  input  logic [PG_W-1:0]               base_page,
  input  logic                          cmd_full,
  output logic                          cmd_push,
  output logic [CMD_W-1:0]              cmd_data
);

  logic                          f_valid;
  logic                          f_kind;
  logic [CPU_W-1:0]              f_cpu;
  logic [pcpa_pkg::ADDR_W-1:0]   f_pa;
  logic                          take;
  logic                          misaligned;
  logic                          below;
  logic                          above;
  logic                          too_far;
  logic                          bad;
  logic [PG_W-1:0]               pg;
  logic [31:0]                   pg_ext;

  assign full     = f_valid && cmd_full;
  assign take     = push && !full;
  assign cmd_push = f_valid && !cmd_full;

  // page number relative to the rounded-up lower bound
  assign pg     = {1'b0, f_pa[pcpa_pkg::ADDR_W-1:PAGE_SHIFT]} - base_page;
  assign pg_ext = 32'(pg);

  assign misaligned = |f_pa[PAGE_SHIFT-1:0];
  assign below      = f_pa < lower_bound;
  assign above      = f_pa >= upper_bound;
  assign too_far    = pg_ext >= 32'(NUM_PAGES);
  assign bad        = (f_kind == pcpa_pkg::KIND_FREE) &&
                      (misaligned || below || above || too_far);

  assign cmd_data = {f_kind, bad, f_cpu, pg_ext[PAGE_W-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (take) begin
      f_valid <= 1'b1;
    end else if (cmd_push) begin
      f_valid <= 1'b0;
    end
    if (take) begin
      f_kind <= kind;
      f_cpu  <= CPU_W'(pcpa_pkg::cpu_wrap(cpu, NUM_CPUS));
      f_pa   <= page_addr;
    end
  end

endmodule

// File: design/pcpa_back.sv
`timescale 1ns / 1ps
module pcpa_back #(
  parameter int NUM_CPUS   = pcpa_pkg::DEF_NUM_CPUS,
  parameter int NUM_PAGES  = pcpa_pkg::DEF_NUM_PAGES,
  parameter int PAGE_SHIFT = pcpa_pkg::DEF_PAGE_SHIFT,
  localparam int CPU_W  = pcpa_pkg::idx_width(NUM_CPUS),
  localparam int PAGE_W = pcpa_pkg::idx_width(NUM_PAGES),
  localparam int PG_W   = pcpa_pkg::ADDR_W + 1 - PAGE_SHIFT,
  localparam int CMD_W  = 2 + CPU_W + PAGE_W,
  localparam int RES_W  = pcpa_pkg::ST_W + pcpa_pkg::ADDR_W
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_empty,
  input  logic [CMD_W-1:0]  cmd_data,
  output logic              cmd_pop,
  input  logic              res_full,
  output logic              res_push,
  output logic [RES_W-1:0]  res_data,
  input  logic [PG_W-1:0]   base_page
);

  localparam int AW = pcpa_pkg::ADDR_W;
  localparam int SUM_W = AW - PAGE_SHIFT;

  typedef enum logic {
    S_IDLE,
    S_POP
  } state_t;

  state_t                state;
  logic [NUM_CPUS-1:0]   nonempty;
  logic [PAGE_W-1:0]     head [NUM_CPUS];
  logic [PAGE_W:0]       link_mem [NUM_PAGES];
  logic [PAGE_W:0]       rd_data;
  logic [CPU_W-1:0]      a_src;
  logic [PAGE_W-1:0]     a_idx;

  logic                  c_kind;
  logic                  c_bad;
  logic [CPU_W-1:0]      c_cpu;
  logic [PAGE_W-1:0]     c_idx;
  logic                  any;
  logic                  own;
  logic [CPU_W-1:0]      low_src;
  logic [CPU_W-1:0]      src;
  logic [CPU_W-1:0]      hsel;
  logic [PAGE_W-1:0]     head_rd;
  logic                  start;
  logic                  mem_we;
  logic                  mem_re;
  logic [PAGE_W:0]       mem_wd;
  logic [SUM_W-1:0]      pg_sum;

  assign c_kind = cmd_data[CMD_W-1];
  assign c_bad  = cmd_data[CMD_W-2];
  assign c_cpu  = cmd_data[PAGE_W +: CPU_W];
  assign c_idx  = cmd_data[PAGE_W-1:0];

  assign any = |nonempty;
  assign own = nonempty[c_cpu];

  // lowest-numbered list that holds a page
  always_comb begin
    low_src = '0;
    for (int i = NUM_CPUS - 1; i >= 0; i--) begin
      if (nonempty[i]) low_src = CPU_W'(i);
    end
  end

  assign src     = own ? c_cpu : low_src;
  assign hsel    = (c_kind == pcpa_pkg::KIND_FREE) ? c_cpu : src;
  assign head_rd = head[hsel];

  // one command at a time; wait out a result still on its way to the queue
  assign start   = (state == S_IDLE) && !cmd_empty && !res_full && !res_push;
  assign cmd_pop = start;

  assign mem_we = start && !c_bad && (c_kind == pcpa_pkg::KIND_FREE);
  assign mem_re = start && !c_bad && (c_kind == pcpa_pkg::KIND_ALLOC) && any;
  assign mem_wd = own ? {1'b1, head_rd} : '0;

  assign pg_sum = base_page[SUM_W-1:0] + SUM_W'(a_idx);

  always_ff @(posedge clk) begin
    if (mem_we) link_mem[c_idx] <= mem_wd;
    if (mem_re) rd_data <= link_mem[head_rd];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      res_push <= 1'b0;
      nonempty <= '0;
    end else begin
      res_push <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            if (c_bad) begin
              res_push <= 1'b1;
              res_data <= {pcpa_pkg::ST_BAD, {AW{1'b0}}};
            end else if (c_kind == pcpa_pkg::KIND_FREE) begin
              head[c_cpu]     <= c_idx;
              nonempty[c_cpu] <= 1'b1;
              res_push        <= 1'b1;
              res_data        <= {pcpa_pkg::ST_DONE, {AW{1'b0}}};
            end else if (!any) begin
              res_push <= 1'b1;
              res_data <= {pcpa_pkg::ST_OOM, {AW{1'b0}}};
            end else begin
              a_src <= src;
              a_idx <= head_rd;
              state <= S_POP;
            end
          end
        end
        S_POP: begin
          if (rd_data[PAGE_W]) head[a_src] <= rd_data[PAGE_W-1:0];
          else nonempty[a_src] <= 1'b0;
          res_push <= 1'b1;
          res_data <= {pcpa_pkg::ST_DONE, pg_sum, {PAGE_SHIFT{1'b0}}};
          state    <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_pop_done: assert property (@(posedge clk) disable iff (rst)
      state == S_POP |=> state == S_IDLE && res_push)
    else $error("pop did not finish in one cycle");

  a_oom: assert property (@(posedge clk) disable iff (rst)
      start && !c_bad && c_kind == pcpa_pkg::KIND_ALLOC && !any
      |=> res_push && res_data[AW +: pcpa_pkg::ST_W] == pcpa_pkg::ST_OOM)
    else $error("allocate with every list empty did not report out of memory");

  a_free_fills: assert property (@(posedge clk) disable iff (rst)
      start && !c_bad && c_kind == pcpa_pkg::KIND_FREE |=> nonempty[$past(c_cpu)])
    else $error("freed page left its list empty");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
      res_push |-> !cmd_pop)
    else $error("command taken while a result is still in flight");

endmodule

// File: design/per_cpu_page_free_list_allocator_core.sv
`timescale 1ns / 1ps
// Per-CPU page allocator: one LIFO free list per CPU, linked through a
// next-link memory with one entry per page. Requests go in through a
// push/full queue port; each gives one item on the pop/empty result port.
// A free pushes an aligned page in [lower_bound, upper_bound) whose index
// from the rounded-up lower bound is below NUM_PAGES onto the requesting
// CPU's list, else returns bad address and changes nothing. An allocate
// pops the own list, steals the head of the lowest-numbered non-empty list
// when its own is empty, and returns out of memory with address 0 when all
// are empty. Lists are empty after reset. The back handles one request at
// a time while the front and the command queue accept more until full; an
// allocate that finds a page also passes through state S_POP, which waits
// for the registered read of the next-link memory before the head can move.
// A result passes the front register, the command queue, the back and the result queue.
// Write lower_bound (offset 0) and upper_bound (offset 4) only while no
// request is in flight.
module per_cpu_page_free_list_allocator_core #(
  parameter int NUM_CPUS   = pcpa_pkg::DEF_NUM_CPUS,
  parameter int NUM_PAGES  = pcpa_pkg::DEF_NUM_PAGES,
  parameter int PAGE_SHIFT = pcpa_pkg::DEF_PAGE_SHIFT
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pcpa_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // requests
  input  logic                          push,
  output logic                          full,
  input  logic                          kind,
  input  logic [pcpa_pkg::CPU_IN_W-1:0] cpu,
  input  logic [pcpa_pkg::ADDR_W-1:0]   page_addr,
  // results
  output logic                          empty,
  input  logic                          pop,
  output logic [pcpa_pkg::ST_W-1:0]     status,
  output logic [pcpa_pkg::ADDR_W-1:0]   granted_addr
);

  localparam int CPU_W  = pcpa_pkg::idx_width(NUM_CPUS);
  localparam int PAGE_W = pcpa_pkg::idx_width(NUM_PAGES);
  localparam int PG_W   = pcpa_pkg::ADDR_W + 1 - PAGE_SHIFT;
  localparam int CMD_W  = 2 + CPU_W + PAGE_W;
  localparam int RES_W  = pcpa_pkg::ST_W + pcpa_pkg::ADDR_W;

  // register select is the word address bit
  localparam logic REG_LOWER = 1'b0;
  localparam logic REG_UPPER = 1'b1;

  logic [pcpa_pkg::ADDR_W-1:0] lower_bound;
  logic [pcpa_pkg::ADDR_W-1:0] upper_bound;
  logic [PG_W-1:0]             base_page;
  logic                        cfg_we;

  logic                        cmd_push;
  logic [CMD_W-1:0]            cmd_din;
  logic                        cmd_full;
  logic                        cmd_pop;
  logic [CMD_W-1:0]            cmd_dout;
  logic                        cmd_empty;

  logic                        res_push;
  logic [RES_W-1:0]            res_din;
  logic                        res_full;
  logic [RES_W-1:0]            res_dout;

  // APB: no wait states, low address bits ignored
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      lower_bound <= pcpa_pkg::DEF_LOWER_BOUND;
      upper_bound <= pcpa_pkg::DEF_UPPER_BOUND;
    end else if (cfg_we) begin
      if (paddr[2] == REG_LOWER) lower_bound <= pwdata;
      if (paddr[2] == REG_UPPER) upper_bound <= pwdata;
    end
  end

  assign prdata = (paddr[2] == REG_UPPER) ? upper_bound : lower_bound;

  // first managed page number: lower_bound rounded up to a page boundary
  assign base_page = {1'b0, lower_bound[pcpa_pkg::ADDR_W-1:PAGE_SHIFT]}
                   + PG_W'(|lower_bound[PAGE_SHIFT-1:0]);

  // front: capture and classify each item
  pcpa_front #(
    .NUM_CPUS  (NUM_CPUS),
    .NUM_PAGES (NUM_PAGES),
    .PAGE_SHIFT(PAGE_SHIFT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .kind       (kind),
    .cpu        (cpu),
    .page_addr  (page_addr),
    .lower_bound(lower_bound),
    .upper_bound(upper_bound),
    .base_page  (base_page),
    .cmd_full   (cmd_full),
    .cmd_push   (cmd_push),
    .cmd_data   (cmd_din)
  );

  // short command queue decouples classification from list updates
  pcpa_queue #(
    .W    (CMD_W),
    .DEPTH(pcpa_pkg::QUEUE_DEPTH)
  ) u_cmd_q (
    .clk  (clk),
    .rst  (rst),
    .push (cmd_push),
    .din  (cmd_din),
    .full (cmd_full),
    .pop  (cmd_pop),
    .dout (cmd_dout),
    .empty(cmd_empty)
  );

  // back: walk the lists and the next-link memory
  pcpa_back #(
    .NUM_CPUS  (NUM_CPUS),
    .NUM_PAGES (NUM_PAGES),
    .PAGE_SHIFT(PAGE_SHIFT)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_empty(cmd_empty),
    .cmd_data (cmd_dout),
    .cmd_pop  (cmd_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res_data (res_din),
    .base_page(base_page)
  );

  // results wait here until popped; the back keeps working until the queue fills
  pcpa_queue #(
    .W    (RES_W),
    .DEPTH(pcpa_pkg::QUEUE_DEPTH)
  ) u_res_q (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .din  (res_din),
    .full (res_full),
    .pop  (pop),
    .dout (res_dout),
    .empty(empty)
  );

  assign status       = res_dout[pcpa_pkg::ADDR_W +: pcpa_pkg::ST_W];
  assign granted_addr = res_dout[pcpa_pkg::ADDR_W-1:0];

endmodule

// File: bench/per_cpu_page_free_list_allocator_core_tb.sv
`timescale 1ns / 1ps
module per_cpu_page_free_list_allocator_core_tb;

  localparam int NCPU     = pcpa_pkg::DEF_NUM_CPUS;
  localparam int NPAGES   = pcpa_pkg::DEF_NUM_PAGES;
  localparam int PG_SHIFT = pcpa_pkg::DEF_PAGE_SHIFT;
  localparam int IDX_W    = $clog2(pcpa_pkg::DEF_NUM_PAGES);
  localparam logic [63:0] PG_MASK = (64'd1 << PG_SHIFT) - 64'd1;

  // register offsets on the config port
  localparam logic [pcpa_pkg::PADDR_W-1:0] REG_LOWER = 3'd0;
  localparam logic [pcpa_pkg::PADDR_W-1:0] REG_UPPER = 3'd4;

  // settle time after the last result before touching registers
  localparam int SETTLE      = 10;
  // one long receiver hold-off, well past what the input queue can absorb
  localparam int LONG_HOLD   = 300;
  // cycles with no handshake on either side before the run is declared hung
  localparam int STALL_LIMIT = 2000;

  logic                          clk;
  logic                          rst       = 1'b1;
  logic                          psel      = 1'b0;
  logic                          penable   = 1'b0;
  logic                          pwrite    = 1'b0;
  logic [pcpa_pkg::PADDR_W-1:0]  paddr     = '0;
  logic [31:0]                   pwdata    = '0;
  logic [31:0]                   prdata;
  logic                          pready;
  logic                          push      = 1'b0;
  logic                          full;
  logic                          kind      = pcpa_pkg::KIND_ALLOC;
  logic [pcpa_pkg::CPU_IN_W-1:0] cpu       = '0;
  logic [pcpa_pkg::ADDR_W-1:0]   page_addr = '0;
  logic                          empty;
  logic                          pop       = 1'b0;
  logic [pcpa_pkg::ST_W-1:0]     status;
  logic [pcpa_pkg::ADDR_W-1:0]   granted_addr;

  // both sides run without random gaps while this is set
  logic steady        = 1'b0;
  // ask the result side for one long hold-off
  logic long_hold_req = 1'b0;

  per_cpu_page_free_list_allocator_core uut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .push         (push),
    .full         (full),
    .kind         (kind),
    .cpu          (cpu),
    .page_addr    (page_addr),
    .empty        (empty),
    .pop          (pop),
    .status       (status),
    .granted_addr (granted_addr)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Allocator shadow: bounds, one LIFO per CPU, next-link per page.
  // ---------------------------------------------------------------------
  logic [31:0]      lo_bound = pcpa_pkg::DEF_LOWER_BOUND;
  logic [31:0]      hi_bound = pcpa_pkg::DEF_UPPER_BOUND;
  logic [IDX_W-1:0] head_pg   [NCPU];
  bit               list_live [NCPU];
  // bit IDX_W marks that another page follows
  logic [IDX_W:0]   next_pg   [NPAGES];
  // pages sitting on some list; steers the stimulus away from double frees
  bit               page_listed [NPAGES];

  int n_freed, n_bad_free, n_grant, n_steal, n_oom, n_cfg_writes, n_mismatch;

  typedef struct {
    pcpa_pkg::status_t st;
    logic [31:0]       ga;
  } grant_t;

  grant_t pending_grants[$];

  // first managed page: lower bound rounded up to a page, kept wide so a
  // bound near the top of the address space does not wrap
  function automatic logic [63:0] page_base();
    return ({32'b0, lo_bound} + PG_MASK) & ~PG_MASK;
  endfunction

  // number of page indices a well-formed free can reach under current bounds
  function automatic int usable_pages();
    logic [63:0] b, span;
    b = page_base();
    if ({32'b0, hi_bound} <= b) return 0;
    span = ({32'b0, hi_bound} - b + PG_MASK) >> PG_SHIFT;
    return (span > NPAGES) ? NPAGES : int'(span);
  endfunction

  // Apply one request to the shadow and return the result it must give.
  function automatic void predict_page_op(input logic k,
                                          input logic [pcpa_pkg::CPU_IN_W-1:0] c,
                                          input logic [31:0] a,
                                          output pcpa_pkg::status_t st,
                                          output logic [31:0] ga);
    logic [63:0]      pa, off;
    logic [IDX_W-1:0] pg;
    logic [IDX_W:0]   link;
    bit               bad, found;
    int               cn, src;
    pa = {32'b0, a};
    cn = int'(c) % NCPU;
    st = pcpa_pkg::ST_DONE;
    ga = '0;
    if (k == pcpa_pkg::KIND_FREE) begin
      bad = ((pa & PG_MASK) != 0) || (a < lo_bound) || (a >= hi_bound);
      off = (pa - page_base()) >> PG_SHIFT;
      if (!bad && off >= NPAGES) bad = 1'b1;
      if (bad) begin
        st = pcpa_pkg::ST_BAD;
        n_bad_free++;
      end else begin
        // push onto this CPU's list; terminate the chain if it was empty
        pg = off[IDX_W-1:0];
        next_pg[pg] = list_live[cn] ? {1'b1, head_pg[cn]} : '0;
        head_pg[cn] = pg;
        list_live[cn] = 1'b1;
        page_listed[pg] = 1'b1;
        n_freed++;
      end
    end else begin
      // own list first, else the lowest-numbered list holding a page
      src = cn;
      found = list_live[cn];
      for (int i = 0; i < NCPU && !found; i++) begin
        if (list_live[i]) begin
          src = i;
          found = 1'b1;
        end
      end
      if (!found) begin
        st = pcpa_pkg::ST_OOM;
        n_oom++;
      end else begin
        pg = head_pg[src];
        link = next_pg[pg];
        if (link[IDX_W]) begin
          head_pg[src] = link[IDX_W-1:0];
        end else begin
          list_live[src] = 1'b0;
          head_pg[src] = '0;
        end
        page_listed[pg] = 1'b0;
        ga = 32'(page_base() + (64'(pg) << PG_SHIFT));
        n_grant++;
        if (src != cn) n_steal++;
      end
    end
  endfunction

  // ---------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------

  // Offer one request, hold it until taken, then log its expected result.
  // A typed expectation overrides the shadow's answer; the shadow still
  // advances so later rows stay in step.
  task automatic issue_request(input logic k, input logic [pcpa_pkg::CPU_IN_W-1:0] c,
                               input logic [31:0] a, input bit typed,
                               input pcpa_pkg::status_t t_st, input logic [31:0] t_ga);
    pcpa_pkg::status_t st;
    logic [31:0]       ga;
    if (!steady) begin
      while ($urandom_range(0, 99) < 20) begin
        push <= 1'b0;
        @(posedge clk);
      end
    end
    push      <= 1'b1;
    kind      <= k;
    cpu       <= c;
    page_addr <= a;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_page_op(k, c, a, st, ga);
    if (typed) begin
      st = t_st;
      ga = t_ga;
    end
    pending_grants.push_back('{st: st, ga: ga});
  endtask

  // Drop push and wait for every outstanding result, then let the pipe settle.
  task automatic wait_drained();
    push <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write one bound register, read it back, and mirror it in the shadow.
  task automatic write_bound(input logic [pcpa_pkg::PADDR_W-1:0] off,
                             input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= off;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (off == REG_LOWER) lo_bound = val;
    else hi_bound = val;
    n_cfg_writes++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== val) begin
      n_mismatch++;
      $display("%0t: readback of offset %0d expected %h got %h", $time, off, val, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Random traffic under the current bounds. Blocks of 40 items swing
  // between free-heavy and alloc-heavy so lists both fill and run dry.
  task automatic random_phase(input int count, input bit mid_hold, input bit mid_drain);
    int          free_pct, pick, np, win, top, pg;
    logic        k;
    logic [31:0] a;
    logic [63:0] b;
    free_pct = 45;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) free_pct = $urandom_range(25, 65);
      if (i == count / 2) begin
        if (mid_hold) long_hold_req <= 1'b1;
        if (mid_drain) wait_drained();
      end
      b    = page_base();
      np   = usable_pages();
      a    = $urandom();
      k    = pcpa_pkg::KIND_ALLOC;
      pick = $urandom_range(0, 99);
      if (pick < 12 || (pick < 12 + free_pct && np == 0)) begin
        // broken frees: anything, misaligned, just under, at the top, past
        // the last page index
        k = pcpa_pkg::KIND_FREE;
        case ($urandom_range(0, 4))
          0: a = $urandom();
          1: a = 32'(b + (64'($urandom_range(0, 63)) << PG_SHIFT)) | $urandom_range(1, 4095);
          2: a = {lo_bound[31:12], 12'h000} - 32'h1000;
          3: a = hi_bound;
          default: a = 32'(b + (64'(NPAGES) << PG_SHIFT));
        endcase
      end else if (pick < 12 + free_pct) begin
        // well-formed free of a page not already on a list; mostly low
        // indices so pages recycle, some from the top of the range
        win = (np < 48) ? np : 48;
        top = (np < 8) ? np : 8;
        for (int t = 0; t < 4 && k == pcpa_pkg::KIND_ALLOC; t++) begin
          pg = ($urandom_range(0, 4) == 0) ? np - 1 - $urandom_range(0, top - 1)
                                           : $urandom_range(0, win - 1);
          if (!page_listed[pg]) begin
            k = pcpa_pkg::KIND_FREE;
            a = 32'(b + (64'(pg) << PG_SHIFT));
          end
        end
      end
      issue_request(k, pcpa_pkg::CPU_IN_W'($urandom_range(0, NCPU - 1)), a, 1'b0,
                    pcpa_pkg::ST_DONE, '0);
    end
  endtask

  // ---------------------------------------------------------------------
  // Directed rows, run under the reset bounds
  // ---------------------------------------------------------------------
  typedef struct {
    logic                          op;
    logic [pcpa_pkg::CPU_IN_W-1:0] core;
    logic [31:0]                   addr;
    bit                            typed;
    pcpa_pkg::status_t             st;
    logic [31:0]                   ga;
  } probe_t;

  probe_t probes [25];

  initial begin : stimulus
    logic [31:0] lo_set [6];
    logic [31:0] hi_set [6];
    int          n_set  [6];

    foreach (list_live[i]) begin
      list_live[i] = 1'b0;
      head_pg[i]   = '0;
    end

    probes = '{
      // nothing freed yet: out of memory
      '{pcpa_pkg::KIND_ALLOC, 3'd0, 32'h0000_0000, 1'b1, pcpa_pkg::ST_OOM,  32'h0},
      // bound and alignment rejects
      '{pcpa_pkg::KIND_FREE,  3'd3, 32'h7FFF_F000, 1'b1, pcpa_pkg::ST_BAD,  32'h0},
      '{pcpa_pkg::KIND_FREE,  3'd3, 32'h8800_0000, 1'b1, pcpa_pkg::ST_BAD,  32'h0},
      '{pcpa_pkg::KIND_FREE,  3'd3, 32'h8000_0800, 1'b1, pcpa_pkg::ST_BAD,  32'h0},
      '{pcpa_pkg::KIND_FREE,  3'd3, 32'hFFFF_F000, 1'b1, pcpa_pkg::ST_BAD,  32'h0},
      '{pcpa_pkg::KIND_FREE,  3'd3, 32'h0000_0000, 1'b1, pcpa_pkg::ST_BAD,  32'h0},
      // first and last page of the range, handed back LIFO
      '{pcpa_pkg::KIND_FREE,  3'd3, 32'h8000_0000, 1'b1, pcpa_pkg::ST_DONE, 32'h0},
      '{pcpa_pkg::KIND_FREE,  3'd3, 32'h87FF_F000, 1'b1, pcpa_pkg::ST_DONE, 32'h0},
      '{pcpa_pkg::KIND_ALLOC, 3'd3, 32'hFFFF_FFFF, 1'b1, pcpa_pkg::ST_DONE, 32'h87FF_F000},
      // empty own list: steal from CPU 3, then run dry
      '{pcpa_pkg::KIND_ALLOC, 3'd5, 32'h0000_0000, 1'b1, pcpa_pkg::ST_DONE, 32'h8000_0000},
      '{pcpa_pkg::KIND_ALLOC, 3'd5, 32'h0000_0000, 1'b1, pcpa_pkg::ST_OOM,  32'h0},
      // steal picks the lowest-numbered list that holds a page
      '{pcpa_pkg::KIND_FREE,  3'd7, 32'h8000_1000, 1'b0, pcpa_pkg::ST_DONE, 32'h0},
      '{pcpa_pkg::KIND_FREE,  3'd2, 32'h8000_2000, 1'b0, pcpa_pkg::ST_DONE, 32'h0},
      '{pcpa_pkg::KIND_FREE,  3'd6, 32'h8000_3000, 1'b0, pcpa_pkg::ST_DONE, 32'h0},
      '{pcpa_pkg::KIND_ALLOC, 3'd0, 32'h1234_5678, 1'b0, pcpa_pkg::ST_DONE, 32'h0},
      '{pcpa_pkg::KIND_ALLOC, 3'd7, 32'h0000_0000, 1'b0, pcpa_pkg::ST_DONE, 32'h0},
      '{pcpa_pkg::KIND_ALLOC, 3'd7, 32'h0000_0000, 1'b0, pcpa_pkg::ST_DONE, 32'h0},
      // same page freed on two CPUs goes undetected; both hand it out
      '{pcpa_pkg::KIND_FREE,  3'd1, 32'h8000_4000, 1'b0, pcpa_pkg::ST_DONE, 32'h0},
      '{pcpa_pkg::KIND_FREE,  3'd2, 32'h8000_4000, 1'b0, pcpa_pkg::ST_DONE, 32'h0},
      '{pcpa_pkg::KIND_ALLOC, 3'd1, 32'h0000_0000, 1'b0, pcpa_pkg::ST_DONE, 32'h0},
      '{pcpa_pkg::KIND_ALLOC, 3'd2, 32'h0000_0000, 1'b0, pcpa_pkg::ST_DONE, 32'h0},
      '{pcpa_pkg::KIND_ALLOC, 3'd4, 32'h0000_0000, 1'b1, pcpa_pkg::ST_OOM,  32'h0},
      // two deep chain on one CPU, left partly full for the random part
      '{pcpa_pkg::KIND_FREE,  3'd0, 32'h8000_5000, 1'b0, pcpa_pkg::ST_DONE, 32'h0},
      '{pcpa_pkg::KIND_FREE,  3'd0, 32'h8000_6000, 1'b0, pcpa_pkg::ST_DONE, 32'h0},
      '{pcpa_pkg::KIND_ALLOC, 3'd0, 32'h0000_0000, 1'b0, pcpa_pkg::ST_DONE, 32'h0}
    };

    // bound settings: reset values, unaligned lower with a small window,
    // full address space, inverted extremes, top of memory, reset again
    lo_set = '{32'h8000_0000, 32'h8000_0123, 32'h0000_0000,
               32'hFFFF_FFFF, 32'hFFFF_0000, 32'h8000_0000};
    hi_set = '{32'h8800_0000, 32'h8004_0000, 32'hFFFF_FFFF,
               32'h0000_0000, 32'hFFFF_FFFF, 32'h8800_0000};
    n_set  = '{450, 350, 400, 100, 300, 350};

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (probes[i]) begin
      issue_request(probes[i].op, probes[i].core, probes[i].addr, probes[i].typed,
                    probes[i].st, probes[i].ga);
    end

    for (int p = 0; p < 6; p++) begin
      wait_drained();
      write_bound(REG_LOWER, lo_set[p]);
      write_bound(REG_UPPER, hi_set[p]);
      // run the full-space setting with no gaps on either side
      steady <= (p == 2);
      // hold the result side off once in the first setting; pause the
      // request side until empty once in the second
      random_phase(n_set[p], p == 0, p == 1);
    end

    wait_drained();

    $display("covered %0d pages freed, %0d frees rejected, %0d grants",
             n_freed, n_bad_free, n_grant);
    $display("  (%0d taken from another CPU), %0d out-of-memory replies, %0d bound writes",
             n_steal, n_oom, n_cfg_writes);
    if (n_mismatch == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // Result side: check the oldest expectation, then decide the next pop.
  // ---------------------------------------------------------------------
  initial begin : result_side
    int     hold_left;
    grant_t exp_grant;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        if (pending_grants.size() == 0) begin
          n_mismatch++;
          $display("%0t: expected no result, got status %0d addr %h", $time, status,
                   granted_addr);
        end else begin
          exp_grant = pending_grants.pop_front();
          if (status !== exp_grant.st) begin
            n_mismatch++;
            $display("%0t: status expected %0d got %0d", $time, exp_grant.st, status);
          end
          if (granted_addr !== exp_grant.ga) begin
            n_mismatch++;
            $display("%0t: granted_addr expected %h got %h", $time, exp_grant.ga,
                     granted_addr);
          end
        end
      end
      if (long_hold_req) begin
        hold_left = LONG_HOLD;
        long_hold_req <= 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= steady || ($urandom_range(0, 99) >= 20);
      end
    end
  end

  // Watchdog: end the run when neither side has moved an item for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    @(negedge rst);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no handshake for %0d cycles, %0d results outstanding", $time,
             STALL_LIMIT, pending_grants.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
